>>> hw/rtl/ptpc_pkg.sv
// Shared types and constants of the PTPv1 UDP frame classifier.
package ptpc_pkg;

	// Frame bound and byte counter width
	localparam int MAX_FRAME_BYTES = 2048;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

	// Header layout
	localparam int ETH_HDR_BYTES   = 14;
	localparam int UDP_HDR_BYTES   = 8;
	localparam int MIN_FRAME_BYTES = 14 + 20 + 8;
	localparam int POS_ETYPE_HI    = 12;
	localparam int POS_ETYPE_LO    = 13;
	localparam int POS_IP_VER_IHL  = 14;
	localparam int POS_IP_PROTO    = 14 + 9;
	localparam int POS_IP_DST0     = 14 + 16;
	localparam int POS_IP_DST1     = 14 + 17;
	localparam int POS_IP_DST2     = 14 + 18;
	localparam int POS_IP_DST3     = 14 + 19;
	localparam int OFS_W           = 7;

	// Field codes
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IHL_MASK       = 4'hF;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// Configuration registers
	typedef enum logic [1:0] {
		REG_ENABLE  = 2'd0,
		REG_GROUP   = 2'd1,
		REG_EVENT   = 2'd2,
		REG_GENERAL = 2'd3
	} cfg_reg_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic        RST_ENABLE  = 1'b1;
	localparam logic [31:0] RST_GROUP   = 32'hE000_0181;
	localparam logic [15:0] RST_EVENT   = 16'd319;
	localparam logic [15:0] RST_GENERAL = 16'd320;

	// Stream widths
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 104;

	// Verdict queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One verdict, fields zeroed on a non-match
	typedef struct packed {
		logic         is_ptp;
		logic [15:0]  matched_port;
		logic [OFS_W-1:0] payload_offset;
		logic [15:0]  payload_length;
		logic         stamp_valid;
		logic [31:0]  stamp_seconds;
		logic [31:0]  stamp_nanoseconds;
	} verdict_t;

	// Queue fill status seen by the front and the back
	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              empty;
	} q_status_t;

endpackage

>>> hw/rtl/ptpv1_udp_frame_classifier.sv
// Top level of the PTPv1 over UDP/IPv4 receive frame classifier.
//
// Frames enter on the slave stream one byte per item, s_tlast on the final
// byte, with the receive timestamp on that same item. Each frame yields one
// verdict item on the master stream: m_tuser says whether it is a PTPv1
// message for the configured group and ports; m_tdata carries the port,
// payload offset, payload length and timestamp, all zero on a non-match.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
//
// Throughput: one byte per cycle while s_tready is high, frames back to
// back with no gap. Path: the length and timestamp of the final byte are
// registered, the verdict is classified from the capture registers and
// pushed into the verdict queue, then presented from the output register.
// Stalls: the four-entry verdict queue absorbs a stalled receiver; s_tready
// drops only once the queue and the verdict in flight would fill it.
// Reset: registers return to enable on, group 224.0.1.129, ports 319/320;
// the byte counter restarts at the start of a frame and no verdict is held.
module ptpv1_udp_frame_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// frame_byte[7:0], stamp_seconds[39:8], stamp_nanoseconds[71:40]
	input  logic [ptpc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// matched_port[15:0], payload_offset[22:16], payload_length[38:23],
	// stamp_valid[39], stamp_seconds_out[71:40], stamp_nanoseconds_out[103:72]
	output logic [ptpc_pkg::M_TDATA_W-1:0]   m_tdata,
	// is_ptp[0]
	output logic                             m_tuser,
	input  logic                             cfg_we,
	input  logic [ptpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ptpc_pkg::*;

	logic      in_fire;
	logic      push;
	logic      pop;
	verdict_t  push_data;
	verdict_t  pop_data;
	q_status_t q_status;

	assign in_fire = s_tvalid && s_tready;

	// Capture and classify
	ptpc_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_fire           (in_fire),
		.frame_byte        (s_tdata[7:0]),
		.last_byte         (s_tlast),
		.stamp_seconds     (s_tdata[39:8]),
		.stamp_nanoseconds (s_tdata[71:40]),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.q_status          (q_status),
		.in_ready          (s_tready),
		.push              (push),
		.push_data         (push_data)
	);

	// Decouple front from output
	ptpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// Deliver verdicts
	ptpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> hw/rtl/ptpc_front.sv
// Front: byte capture, configuration registers and per-frame classification.
module ptpc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_fire,
	input  logic [7:0]                       frame_byte,
	input  logic                             last_byte,
	input  logic [31:0]                      stamp_seconds,
	input  logic [31:0]                      stamp_nanoseconds,
	input  logic                             cfg_we,
	input  logic [ptpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  ptpc_pkg::q_status_t              q_status,
	output logic                             in_ready,
	output logic                             push,
	output ptpc_pkg::verdict_t               push_data
);
	import ptpc_pkg::*;

	logic              enable_q;
	logic [31:0]       group_q;
	logic [15:0]       event_q;
	logic [15:0]       general_q;

	logic [POS_W-1:0]  pos_q;
	logic [15:0]       etype_q;
	logic [3:0]        version_q;
	logic [3:0]        ihl_q;
	logic [7:0]        proto_q;
	logic [31:0]       dst_q;
	logic [15:0]       uport_q;
	logic [15:0]       ulen_q;

	logic              valid_s1;
	logic [POS_W-1:0]  len_s1;
	logic [31:0]       sec_s1;
	logic [31:0]       nsec_s1;

	logic              cap_en;
	logic [OFS_W-1:0]  udp_base;
	logic [OFS_W-1:0]  payload_ofs;
	logic [POS_W-1:0]  pos_inc;
	logic [31:0]       group_next;
	logic              match;
	logic [QCNT_W-1:0] pending;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= RST_ENABLE;
			group_q   <= RST_GROUP;
			event_q   <= RST_EVENT;
			general_q <= RST_GENERAL;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_GROUP:   group_q   <= cfg_data[31:0];
				REG_EVENT:   event_q   <= cfg_data[15:0];
				REG_GENERAL: general_q <= cfg_data[15:0];
			endcase
		end
	end

	// UDP header start follows the IHL of this frame
	assign cap_en   = (pos_q < POS_W'(MAX_FRAME_BYTES));
	assign udp_base = OFS_W'(ETH_HDR_BYTES) + {1'b0, ihl_q, 2'b00};
	assign pos_inc  = cap_en ? pos_q + POS_W'(1) : pos_q;

	// Advance the byte counter, saturating at the frame bound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_fire) begin
			pos_q <= last_byte ? '0 : pos_inc;
		end
	end

	// Capture header fields at their byte positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etype_q <= '0;
			ihl_q   <= '0;
			uport_q <= '0;
			ulen_q  <= '0;
		end else if (in_fire && cap_en) begin
			if (pos_q == POS_W'(POS_ETYPE_HI)) etype_q[15:8] <= frame_byte;
			if (pos_q == POS_W'(POS_ETYPE_LO)) etype_q[7:0]  <= frame_byte;
			if (pos_q == POS_W'(POS_IP_VER_IHL)) ihl_q <= frame_byte[3:0] & IHL_MASK;
			if (pos_q > POS_W'(ETH_HDR_BYTES)) begin
				if (pos_q == POS_W'(udp_base) + POS_W'(2)) uport_q[15:8] <= frame_byte;
				if (pos_q == POS_W'(udp_base) + POS_W'(3)) uport_q[7:0]  <= frame_byte;
				if (pos_q == POS_W'(udp_base) + POS_W'(4)) ulen_q[15:8]  <= frame_byte;
				if (pos_q == POS_W'(udp_base) + POS_W'(5)) ulen_q[7:0]   <= frame_byte;
			end
		end
	end

	// Keep the IP header bytes the verdict looks at
	always_ff @(posedge clk) begin
		if (in_fire && cap_en) begin
			if (pos_q == POS_W'(POS_IP_VER_IHL)) version_q    <= frame_byte[7:4];
			if (pos_q == POS_W'(POS_IP_PROTO))   proto_q      <= frame_byte;
			if (pos_q == POS_W'(POS_IP_DST0))    dst_q[31:24] <= frame_byte;
			if (pos_q == POS_W'(POS_IP_DST1))    dst_q[23:16] <= frame_byte;
			if (pos_q == POS_W'(POS_IP_DST2))    dst_q[15:8]  <= frame_byte;
			if (pos_q == POS_W'(POS_IP_DST3))    dst_q[7:0]   <= frame_byte;
		end
	end

	// Register frame length and timestamp when the last byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_byte) begin
			len_s1  <= pos_inc;
			sec_s1  <= stamp_seconds;
			nsec_s1 <= stamp_nanoseconds;
		end
	end

	// Classify from the settled capture registers
	assign group_next  = group_q + 32'd1;
	assign payload_ofs = udp_base + OFS_W'(UDP_HDR_BYTES);

	always_comb begin
		match = enable_q
			&& (len_s1 >= POS_W'(MIN_FRAME_BYTES))
			&& (etype_q == ETHERTYPE_IPV4)
			&& (version_q == IP_VERSION_4)
			&& (proto_q == PROTO_UDP)
			&& ((dst_q == group_q) || (dst_q == group_next))
			&& (POS_W'(payload_ofs) <= len_s1)
			&& ((uport_q == event_q) || (uport_q == general_q))
			&& (ulen_q >= 16'(UDP_HDR_BYTES));
	end

	// Build the verdict, zeroed unless it matches
	always_comb begin
		push_data = '0;
		if (match) begin
			push_data.is_ptp            = 1'b1;
			push_data.matched_port      = uport_q;
			push_data.payload_offset    = payload_ofs;
			push_data.payload_length    = ulen_q - 16'(UDP_HDR_BYTES);
			push_data.stamp_valid       = (|sec_s1) | (|nsec_s1);
			push_data.stamp_seconds     = sec_s1;
			push_data.stamp_nanoseconds = nsec_s1;
		end
	end

	assign push = valid_s1;

	// Take an item only while the queue has room for a verdict in flight
	assign pending  = q_status.level + QCNT_W'(valid_s1);
	assign in_ready = (pending < QCNT_W'(QUEUE_DEPTH));

endmodule

>>> hw/rtl/ptpc_queue.sv
// Short verdict queue between the front and the output stage.
module ptpc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ptpc_pkg::verdict_t  push_data,
	input  logic                pop,
	output ptpc_pkg::verdict_t  pop_data,
	output ptpc_pkg::q_status_t status
);
	import ptpc_pkg::*;

	verdict_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// Store pushed verdicts
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign status.level = count_q;
	assign status.empty = (count_q == '0);

endmodule

>>> hw/rtl/ptpc_back.sv
// Back: output register that hands verdicts to the master stream.
module ptpc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ptpc_pkg::q_status_t               q_status,
	input  ptpc_pkg::verdict_t                q_data,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ptpc_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tuser
);
	import ptpc_pkg::*;

	logic     valid_q;
	verdict_t data_q;

	// Refill the output register when it is empty or being taken
	assign pop = !q_status.empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) data_q <= q_data;
	end

	// Pack fields from the lowest bit up
	assign m_tvalid = valid_q;
	assign m_tuser  = data_q.is_ptp;
	assign m_tdata  = {data_q.stamp_nanoseconds, data_q.stamp_seconds,
		data_q.stamp_valid, data_q.payload_length, data_q.payload_offset,
		data_q.matched_port};

endmodule

>>> dv/tb_ptpv1_udp_frame_classifier.sv
// Testbench for the PTPv1 over UDP/IPv4 frame classifier: stream stimulus and verdict checks.
`timescale 1ns / 1ps

module tb_ptpv1_udp_frame_classifier;
	import ptpc_pkg::*;

	typedef logic [7:0] byte_q_t [$];

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// frame_byte[7:0], stamp_seconds[39:8], stamp_nanoseconds[71:40]
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// matched_port[15:0], payload_offset[22:16], payload_length[38:23],
	// stamp_valid[39], stamp_seconds_out[71:40], stamp_nanoseconds_out[103:72]
	logic [M_TDATA_W-1:0]  m_tdata;
	// is_ptp[0]
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies, as last written
	logic        cfg_enable  = RST_ENABLE;
	logic [31:0] cfg_group   = RST_GROUP;
	logic [15:0] cfg_event   = RST_EVENT;
	logic [15:0] cfg_general = RST_GENERAL;

	// Frame capture state of the predictor
	int unsigned seen_bytes = 0;
	logic [7:0]  ip_copy [20] = '{default: 8'h00};
	logic [15:0] etype_seen = '0;
	logic [3:0]  ihl_seen   = '0;
	logic [15:0] dport_seen = '0;
	logic [15:0] ulen_seen  = '0;

	verdict_t    verdicts_due [$];
	int unsigned mismatches    = 0;
	int unsigned src_idle_pct  = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned stall_left    = 0;

	ptpv1_udp_frame_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Capture one accepted byte; on the final byte queue the expected verdict
	task automatic classify_byte(input logic [7:0] b, input logic last,
			input logic [31:0] sec, input logic [31:0] nsec);
		int unsigned base;
		int unsigned len;
		logic [31:0] dst;
		verdict_t    v;
		if (seen_bytes < MAX_FRAME_BYTES) begin
			if (seen_bytes == POS_ETYPE_HI) etype_seen[15:8] = b;
			if (seen_bytes == POS_ETYPE_LO) etype_seen[7:0] = b;
			if (seen_bytes >= ETH_HDR_BYTES && seen_bytes < ETH_HDR_BYTES + 20)
				ip_copy[seen_bytes - ETH_HDR_BYTES] = b;
			if (seen_bytes == POS_IP_VER_IHL) ihl_seen = b[3:0];
			base = ETH_HDR_BYTES + 4 * ihl_seen;
			// UDP fields sit after the IP header, even where it overlaps stored bytes
			if (seen_bytes > ETH_HDR_BYTES) begin
				if (seen_bytes == base + 2) dport_seen[15:8] = b;
				if (seen_bytes == base + 3) dport_seen[7:0] = b;
				if (seen_bytes == base + 4) ulen_seen[15:8] = b;
				if (seen_bytes == base + 5) ulen_seen[7:0] = b;
			end
			seen_bytes++;
		end
		if (!last) return;
		len = seen_bytes;
		seen_bytes = 0;
		base = ETH_HDR_BYTES + 4 * ihl_seen;
		dst = {ip_copy[16], ip_copy[17], ip_copy[18], ip_copy[19]};
		v = '0;
		if (cfg_enable && len >= MIN_FRAME_BYTES && etype_seen == ETHERTYPE_IPV4
				&& ip_copy[0][7:4] == IP_VERSION_4 && ip_copy[9] == PROTO_UDP
				&& (dst == cfg_group || dst == cfg_group + 32'd1)
				&& base + UDP_HDR_BYTES <= len
				&& (dport_seen == cfg_event || dport_seen == cfg_general)
				&& ulen_seen >= 16'd8) begin
			v.is_ptp            = 1'b1;
			v.matched_port      = dport_seen;
			v.payload_offset    = OFS_W'(base + UDP_HDR_BYTES);
			v.payload_length    = ulen_seen - 16'd8;
			v.stamp_valid       = (sec != 0 || nsec != 0);
			v.stamp_seconds     = sec;
			v.stamp_nanoseconds = nsec;
		end
		verdicts_due.push_back(v);
	endtask

	// Offer one byte, idling at random first; predict once it is taken
	task automatic send_byte(input logic [7:0] b, input logic last,
			input logic [31:0] sec, input logic [31:0] nsec);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {nsec, sec, b};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		classify_byte(b, last, sec, nsec);
	endtask

	// Send a whole frame; the timestamp only matters on the final byte
	task automatic send_frame(input byte_q_t f, input logic [31:0] sec, input logic [31:0] nsec);
		int unsigned last_i;
		last_i = f.size() - 1;
		foreach (f[i]) begin
			if (i == last_i) send_byte(f[i], 1'b1, sec, nsec);
			else send_byte(f[i], 1'b0, $urandom, $urandom);
		end
	endtask

	// Fill a frame with random bytes, then lay the header fields over it
	task automatic build_frame(output byte_q_t f, input int unsigned len,
			input logic [15:0] etype, input logic [7:0] ver_ihl, input logic [7:0] proto,
			input logic [31:0] dst, input logic [15:0] dport, input logic [15:0] ulen);
		int unsigned base;
		int unsigned pos [12];
		logic [7:0]  val [12];
		f = {};
		repeat (len) f.push_back(8'($urandom));
		base = ETH_HDR_BYTES + 4 * ver_ihl[3:0];
		pos = '{POS_ETYPE_HI, POS_ETYPE_LO, POS_IP_VER_IHL, POS_IP_PROTO, POS_IP_DST0,
			POS_IP_DST1, POS_IP_DST2, POS_IP_DST3, base + 2, base + 3, base + 4, base + 5};
		val = '{etype[15:8], etype[7:0], ver_ihl, proto, dst[31:24], dst[23:16], dst[15:8],
			dst[7:0], dport[15:8], dport[7:0], ulen[15:8], ulen[7:0]};
		// UDP fields go last so that they win where a short header overlaps them
		foreach (pos[k]) if (pos[k] < len) f[pos[k]] = val[k];
	endtask

	task automatic send_built(input int unsigned len, input logic [15:0] etype,
			input logic [7:0] ver_ihl, input logic [7:0] proto, input logic [31:0] dst,
			input logic [15:0] dport, input logic [15:0] ulen,
			input logic [31:0] sec, input logic [31:0] nsec);
		byte_q_t f;
		build_frame(f, len, etype, ver_ihl, proto, dst, dport, ulen);
		send_frame(f, sec, nsec);
	endtask

	// Drop valid and wait until every verdict is in and the pipeline is empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all four registers while idle
	task automatic configure(input logic en, input logic [31:0] grp,
			input logic [15:0] evp, input logic [15:0] gnp);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ENABLE;
		cfg_data  <= {31'd0, en};
		@(posedge clk);
		cfg_index <= REG_GROUP;
		cfg_data  <= grp;
		@(posedge clk);
		cfg_index <= REG_EVENT;
		cfg_data  <= {16'd0, evp};
		@(posedge clk);
		cfg_index <= REG_GENERAL;
		cfg_data  <= {16'd0, gnp};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_enable  = en;
		cfg_group   = grp;
		cfg_event   = evp;
		cfg_general = gnp;
	endtask

	task automatic pick_stamp(output logic [31:0] sec, output logic [31:0] nsec);
		sec  = $urandom;
		nsec = $urandom;
		case ($urandom_range(9))
			0: begin
				sec  = '0;
				nsec = '0;
			end
			1: sec = '0;
			2: nsec = '0;
			default: ;
		endcase
	endtask

	// Mostly well-formed PTP frames, some with one field broken, some noise
	task automatic random_frame(output byte_q_t f);
		int unsigned kind;
		int unsigned ihl;
		int unsigned min_len;
		int unsigned len;
		logic [15:0] etype;
		logic [7:0]  vi;
		logic [7:0]  proto;
		logic [31:0] dst;
		logic [15:0] dport;
		logic [15:0] ulen;
		kind = $urandom_range(99);
		if (kind < 12) begin
			f = {};
			repeat ($urandom_range(1, 45)) f.push_back(8'($urandom));
			return;
		end
		ihl     = ($urandom_range(99) < 60) ? 5 : $urandom_range(0, 15);
		min_len = ETH_HDR_BYTES + 4 * ihl + UDP_HDR_BYTES;
		if (min_len < MIN_FRAME_BYTES) min_len = MIN_FRAME_BYTES;
		len   = min_len + $urandom_range(0, 4);
		etype = ETHERTYPE_IPV4;
		vi    = {IP_VERSION_4, 4'(ihl)};
		proto = PROTO_UDP;
		dst   = $urandom_range(1) ? cfg_group : cfg_group + 32'd1;
		dport = $urandom_range(1) ? cfg_event : cfg_general;
		ulen  = 16'($urandom_range(8, 65535));
		if (kind >= 70) begin
			case ($urandom_range(7))
				0: etype = 16'($urandom);
				1: vi[7:4] = 4'($urandom);
				2: proto = 8'($urandom);
				3: dst = $urandom;
				4: dport = 16'($urandom);
				5: ulen = 16'($urandom_range(0, 7));
				6: len = $urandom_range(1, min_len - 1);
				default: ulen = 16'd8;
			endcase
		end
		build_frame(f, len, etype, vi, proto, dst, dport, ulen);
	endtask

	// Receiver: hold off while a stall is pending, else idle at random
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Compare each verdict item with the oldest one due
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: verdict with none due, tuser %0b tdata %h",
						$time, m_tuser, m_tdata);
			end else begin
				want = verdicts_due.pop_front();
				check_field("is_ptp", 32'(want.is_ptp), 32'(m_tuser));
				check_field("matched_port", 32'(want.matched_port), 32'(m_tdata[15:0]));
				check_field("payload_offset", 32'(want.payload_offset),
					32'(m_tdata[22:16]));
				check_field("payload_length", 32'(want.payload_length),
					32'(m_tdata[38:23]));
				check_field("stamp_valid", 32'(want.stamp_valid), 32'(m_tdata[39]));
				check_field("stamp_seconds", want.stamp_seconds, m_tdata[71:40]);
				check_field("stamp_nanoseconds", want.stamp_nanoseconds, m_tdata[103:72]);
			end
		end
	end

	// Field extremes, failing checks, the length bound and short-header overlaps
	task automatic test_directed_frames();
		logic [31:0] g;
		logic [15:0] e;
		logic [15:0] n;
		logic [7:0]  v45;
		byte_q_t     f;
		g   = cfg_group;
		e   = cfg_event;
		n   = cfg_general;
		v45 = {IP_VERSION_4, 4'd5};
		send_built(42, ETHERTYPE_IPV4, v45, PROTO_UDP, g, e, 16'd8, $urandom, $urandom);
		send_built(42, 16'h86DD, v45, PROTO_UDP, g, e, 16'd30, $urandom, $urandom);
		send_built(42, ETHERTYPE_IPV4, v45, 8'd6, g, e, 16'd30, $urandom, $urandom);
		send_built(42, ETHERTYPE_IPV4, v45, PROTO_UDP, g + 32'd2, e, 16'd30, $urandom, $urandom);
		send_built(42, ETHERTYPE_IPV4, v45, PROTO_UDP, g, n + 16'd1, 16'd30, $urandom, $urandom);
		send_built(42, ETHERTYPE_IPV4, v45, PROTO_UDP, g, e, 16'd7, $urandom, $urandom);
		// one byte short of the minimum
		send_built(41, ETHERTYPE_IPV4, v45, PROTO_UDP, g, e, 16'd20, $urandom, $urandom);
		// header length of zero words: UDP fields land in the stored IP header
		send_built(42, ETHERTYPE_IPV4, {IP_VERSION_4, 4'd0}, PROTO_UDP, g + 32'd1, n,
			16'hFFFF, 0, 0);
		// largest header, exactly long enough
		send_built(82, ETHERTYPE_IPV4, {IP_VERSION_4, 4'd15}, PROTO_UDP, g, n, 16'd8,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		f = {};
		f.push_back(8'($urandom));
		send_frame(f, $urandom, $urandom);
	endtask

	// Disabled classifier, all-ones group with wrap to zero
	task automatic test_register_extremes();
		logic [7:0] v45;
		v45 = {IP_VERSION_4, 4'd5};
		configure(1'b0, RST_GROUP, RST_EVENT, RST_GENERAL);
		send_built(42, ETHERTYPE_IPV4, v45, PROTO_UDP, RST_GROUP, RST_EVENT, 16'd30,
			$urandom, $urandom);
		configure(1'b1, 32'hFFFF_FFFF, 16'd1234, 16'd1234);
		send_built(42, ETHERTYPE_IPV4, v45, PROTO_UDP, 32'd0, 16'd1234, 16'd30, $urandom, $urandom);
	endtask

	task automatic test_random_traffic(input int unsigned frames);
		byte_q_t     f;
		logic [31:0] sec;
		logic [31:0] nsec;
		repeat (frames) begin
			random_frame(f);
			pick_stamp(sec, nsec);
			send_frame(f, sec, nsec);
		end
	endtask

	// Hold the receiver off while one-byte frames flood the verdict queue
	task automatic test_output_stall();
		byte_q_t f;
		stall_left = 60;
		repeat (12) begin
			f = {};
			f.push_back(8'($urandom));
			send_frame(f, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [15:0] shared_port;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct  = 14;
		sink_idle_pct = 46;
		test_directed_frames();
		test_register_extremes();
		src_idle_pct  = 46;
		sink_idle_pct = 14;
		configure(1'b1, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
		test_random_traffic(1);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		shared_port = 16'($urandom);
		configure(1'b1, $urandom, shared_port, shared_port);
		test_random_traffic(1);
		test_output_stall();
		wait_idle();
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/ptpc_pkg.sv
hw/rtl/ptpc_front.sv
hw/rtl/ptpc_queue.sv
hw/rtl/ptpc_back.sv
hw/rtl/ptpv1_udp_frame_classifier.sv
dv/tb_ptpv1_udp_frame_classifier.sv
